FILE: rtl/best_fit_segment_allocator_macros.svh
// ---------------------------------------------------------------------------
// best-fit segment allocator assertion macros
// implication checks on clk, held off during rst
// ---------------------------------------------------------------------------
`ifndef BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH
`define BEST_FIT_SEGMENT_ALLOCATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define BFSA_CHECK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define BFSA_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BFSA_CHECK_SAME(label, ante, cons, msg)

`define BFSA_CHECK_NEXT(label, ante, cons, msg)

`endif

`endif

FILE: rtl/bfsa_pkg.sv
// ---------------------------------------------------------------------------
// bfsa_pkg
// shared types and codes of the best-fit segment allocator
// ---------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

  localparam logic ACT_ADD   = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_PLACED  = 3'd2;
  localparam logic [2:0] ST_NOFIT   = 3'd3;
  localparam logic [2:0] ST_SKIPPED = 3'd4;

  localparam int BASE_W = 16;
  localparam int SIZE_W = 17;
  localparam int OWNER_W = 8;
  localparam int STAT_W = 3;
  localparam int ENT_W = BASE_W + SIZE_W;
  localparam int SUM_W = SIZE_W + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SNAP,
    S_SCAN,
    S_MOD,
    S_CARVE,
    S_FIN,
    S_ROLL,
    S_RESP
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SW_NONE,
    SW_SNAP,
    SW_SCAN,
    SW_ROLL
  } sweep_t;

  typedef struct packed {
    logic   capture;
    logic   add;
    logic   open;
    logic   skip;
    sweep_t sweep;
    logic   idx_clr;
    logic   mod_init;
    logic   carve;
    logic   finish;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic is_open;
    logic is_failed;
    logic is_last;
    logic sweep_done;
    logic found;
    logic mod_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/bfsa_ctrl.sv
// ---------------------------------------------------------------------------
// bfsa_ctrl
// sequencer for add, skip, snapshot, best-fit scan, modulo wait, carve, rollback and response
// ---------------------------------------------------------------------------
`default_nettype none

module bfsa_ctrl
  import bfsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.sweep = SW_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (!sts.is_alloc) begin
          cmd.add = 1'b1;
          state_next = S_RESP;
        end else if (!sts.is_open) begin
          cmd.open = 1'b1;
          cmd.idx_clr = 1'b1;
          state_next = S_SNAP;
        end else if (sts.is_failed) begin
          cmd.skip = 1'b1;
          state_next = S_FIN;
        end else begin
          cmd.idx_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SNAP: begin
        cmd.sweep = SW_SNAP;
        if (sts.sweep_done) begin
          cmd.idx_clr = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.sweep = SW_SCAN;
        if (sts.sweep_done) begin
          cmd.mod_init = 1'b1;
          state_next = sts.found ? S_MOD : S_FIN;
        end
      end
      S_MOD: begin
        if (sts.mod_done) begin
          state_next = S_CARVE;
        end
      end
      S_CARVE: begin
        cmd.carve = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.is_last && sts.is_failed) begin
          cmd.idx_clr = 1'b1;
          state_next = S_ROLL;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end
      end
      S_ROLL: begin
        cmd.sweep = SW_ROLL;
        if (sts.sweep_done) begin
          cmd.finish = 1'b1;
          state_next = S_RESP;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/bfsa_dp.sv
// ---------------------------------------------------------------------------
// bfsa_dp
// hole table, snapshot memory, scan compare, modulo reduction, result regs
// ---------------------------------------------------------------------------
`default_nettype none

module bfsa_dp
  import bfsa_pkg::*;
#(
  parameter int MAX_HOLES = 16,
  parameter int MEM_WORDS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dp_cmd_t             cmd,
  output dp_sts_t                  sts,
  input  wire logic                action,
  input  wire logic [BASE_W-1:0]   region_base,
  input  wire logic [SIZE_W-1:0]   region_size,
  input  wire logic [OWNER_W-1:0]  owner_id,
  input  wire logic                last_segment,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [BASE_W-1:0]        placed_base,
  output logic [OWNER_W-1:0]       owner_echo,
  output logic                     process_done,
  output logic                     process_committed
);

  localparam int CNT_W = $clog2(MAX_HOLES + 1);
  localparam int IDX_W = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int SUM_LIM = (1 << SUM_W) - 1;
  localparam int MOD_STEPS = (MEM_WORDS <= SUM_LIM) ? $clog2(SUM_LIM / MEM_WORDS + 1) : 0;
  localparam int MOD_TOP = (MOD_STEPS > 0) ? (MEM_WORDS << (MOD_STEPS - 1)) : 0;
  localparam int MCNT_W = (MOD_STEPS > 0) ? $clog2(MOD_STEPS + 1) : 1;

  logic [ENT_W-1:0] tab_mem [MAX_HOLES];
  logic [ENT_W-1:0] snap_mem [MAX_HOLES];

  logic               in_act;
  logic [BASE_W-1:0]  in_base;
  logic [SIZE_W-1:0]  in_size;
  logic [OWNER_W-1:0] in_owner;
  logic               in_last;

  logic [CNT_W-1:0] count;
  logic             open;
  logic             failed;

  logic [CNT_W-1:0] idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;
  logic [ENT_W-1:0] tab_rd;
  logic [ENT_W-1:0] snap_rd;

  logic              found;
  logic [IDX_W-1:0]  best_idx;
  logic [SIZE_W-1:0] best_len;
  logic [BASE_W-1:0] best_start;

  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  dsh;
  logic [MCNT_W-1:0] mcnt;

  logic [STAT_W-1:0] res_status;
  logic [BASE_W-1:0] res_placed;
  logic              res_done;
  logic              res_comm;

  logic              full;
  logic              issue;
  logic              tab_we;
  logic [IDX_W-1:0]  tab_wa;
  logic [ENT_W-1:0]  tab_wd;
  logic              snap_we;
  logic [IDX_W-1:0]  snap_wa;
  logic [ENT_W-1:0]  snap_wd;
  logic [SIZE_W-1:0] scan_len;
  logic [BASE_W-1:0] scan_start;
  logic              scan_take;

  assign full = (count == CNT_W'(MAX_HOLES));
  assign issue = (cmd.sweep != SW_NONE) && !cmd.idx_clr && (idx != count);
  assign scan_len = tab_rd[SIZE_W-1:0];
  assign scan_start = tab_rd[ENT_W-1:SIZE_W];
  assign scan_take = (cmd.sweep == SW_SCAN) && rd_vld && (in_size <= scan_len) &&
                     (!found || (scan_len < best_len));

  // table write port
  always_comb begin
    tab_we = 1'b0;
    tab_wa = count[IDX_W-1:0];
    tab_wd = {in_base, in_size};
    priority if (cmd.add && !full) begin
      tab_we = 1'b1;
    end else if (cmd.carve) begin
      tab_we = 1'b1;
      tab_wa = best_idx;
      tab_wd = {rem[BASE_W-1:0], best_len - in_size};
    end else if ((cmd.sweep == SW_ROLL) && rd_vld) begin
      tab_we = 1'b1;
      tab_wa = rd_idx;
      tab_wd = snap_rd;
    end else begin
      tab_we = 1'b0;
    end
  end

  // snapshot write port
  always_comb begin
    snap_we = 1'b0;
    snap_wa = count[IDX_W-1:0];
    snap_wd = {in_base, in_size};
    priority if (cmd.add && !full && open) begin
      snap_we = 1'b1;
    end else if ((cmd.sweep == SW_SNAP) && rd_vld) begin
      snap_we = 1'b1;
      snap_wa = rd_idx;
      snap_wd = tab_rd;
    end else begin
      snap_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wa] <= tab_wd;
    end
    if (snap_we) begin
      snap_mem[snap_wa] <= snap_wd;
    end
    if (issue) begin
      tab_rd <= tab_mem[idx[IDX_W-1:0]];
      snap_rd <= snap_mem[idx[IDX_W-1:0]];
      rd_idx <= idx[IDX_W-1:0];
    end
  end

  // sweep index and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      rd_vld <= 1'b0;
    end else if (cmd.idx_clr) begin
      idx <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  // best-fit tracking
  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      found <= 1'b0;
    end else if (scan_take) begin
      found <= 1'b1;
      best_idx <= rd_idx;
      best_len <= scan_len;
      best_start <= scan_start;
    end
  end

  // restoring reduction of start plus size by the memory size
  always_ff @(posedge clk) begin
    if (rst) begin
      mcnt <= '0;
    end else if (cmd.mod_init && found) begin
      rem <= SUM_W'(best_start) + SUM_W'(in_size);
      dsh <= SUM_W'(MOD_TOP);
      mcnt <= MCNT_W'(MOD_STEPS);
    end else if (mcnt != '0) begin
      if (rem >= dsh) begin
        rem <= rem - dsh;
      end
      dsh <= dsh >> 1;
      mcnt <= mcnt - MCNT_W'(1);
    end
  end

  // captured word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_act <= action;
      in_base <= region_base;
      in_size <= region_size;
      in_owner <= owner_id;
      in_last <= last_segment;
    end
  end

  // table count and process flags
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      open <= 1'b0;
      failed <= 1'b0;
    end else begin
      if (cmd.add && !full) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.open) begin
        open <= 1'b1;
        failed <= 1'b0;
      end
      if (cmd.mod_init && !found) begin
        failed <= 1'b1;
      end
      if (cmd.finish && in_last) begin
        open <= 1'b0;
        failed <= 1'b0;
      end
    end
  end

  // result of the current word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      res_placed <= '0;
      res_done <= 1'b0;
      res_comm <= 1'b0;
    end
    if (cmd.add) begin
      res_status <= full ? ST_FULL : ST_ADDED;
    end
    if (cmd.skip) begin
      res_status <= ST_SKIPPED;
    end
    if (cmd.mod_init && !found) begin
      res_status <= ST_NOFIT;
    end
    if (cmd.carve) begin
      res_status <= ST_PLACED;
      res_placed <= best_start;
    end
    if (cmd.finish && in_last) begin
      res_done <= 1'b1;
      res_comm <= !failed;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= res_status;
      placed_base <= res_placed;
      owner_echo <= in_owner;
      process_done <= res_done;
      process_committed <= res_comm;
    end
  end

  always_comb begin
    sts.is_alloc = (in_act == ACT_ALLOC);
    sts.is_open = open;
    sts.is_failed = failed;
    sts.is_last = in_last;
    sts.sweep_done = (idx == count) && !rd_vld;
    sts.found = found;
    sts.mod_done = (mcnt == '0);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

FILE: rtl/best_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// best_fit_segment_allocator
// best-fit hole table with per-process snapshot and rollback
// ---------------------------------------------------------------------------
//   channel   handshake              payload
//   in        in_valid / in_ready    action region_base region_size owner_id last_segment
//   out       out_valid / out_ready  status placed_base owner_echo process_done
//                                    process_committed
//
// one word at a time; an add writes the table, a skip passes over the scan; an allocate
// scans the n holes, then on a fit runs the s modulo steps (2 for 64k) and carves;
// a process start first copies the table into the snapshot, and a failed last segment
// copies the snapshot back into the table for the rollback
// one read port per memory, so each sweep reads the holes in turn; rst clears counts and flags only
// a new word is taken while the previous result waits; its result holds until out_ready
// ---------------------------------------------------------------------------
`default_nettype none

module best_fit_segment_allocator
  import bfsa_pkg::*;
#(
  parameter int MAX_HOLES = 16,
  parameter int MEM_WORDS = 65536
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  input  wire logic [BASE_W-1:0]   region_base,
  input  wire logic [SIZE_W-1:0]   region_size,
  input  wire logic [OWNER_W-1:0]  owner_id,
  input  wire logic                last_segment,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STAT_W-1:0]        status,
  output logic [BASE_W-1:0]        placed_base,
  output logic [OWNER_W-1:0]       owner_echo,
  output logic                     process_done,
  output logic                     process_committed
);

`include "best_fit_segment_allocator_macros.svh"

  dp_cmd_t cmd;
  dp_sts_t sts;

  bfsa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bfsa_dp #(
    .MAX_HOLES (MAX_HOLES),
    .MEM_WORDS (MEM_WORDS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .action            (action),
    .region_base       (region_base),
    .region_size       (region_size),
    .owner_id          (owner_id),
    .last_segment      (last_segment),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .placed_base       (placed_base),
    .owner_echo        (owner_echo),
    .process_done      (process_done),
    .process_committed (process_committed)
  );

  `BFSA_CHECK_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready while busy")
  `BFSA_CHECK_SAME(a_load_when_free, cmd.out_load, !out_valid || out_ready, "result overrun")
  `BFSA_CHECK_SAME(a_commit_needs_done, out_valid && process_committed, process_done, "commit without done")
  `BFSA_CHECK_SAME(a_placed_base_zero, out_valid && (status != ST_PLACED), placed_base == '0, "base on unplaced")

endmodule

`default_nettype wire

FILE: tb/tb_best_fit_segment_allocator.sv
// ---------------------------------------------------------------------------
// tb_best_fit_segment_allocator
// Checks the best-fit allocator against a cycle-free prediction of its hole
// table, snapshot and rollback. Directed words hit the edge cases, then
// random processes of a few segments with random stalls on both channels.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_best_fit_segment_allocator;
  import bfsa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_HOLES = 16;
  localparam int RANDOM_WORDS = 930;
  localparam int PAUSE_AT = 500;
  localparam int HOLD_AT = 250;
  localparam int LONG_HOLD = 400;
  localparam int DRAIN_CYCLES = 120;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic               action;
    logic [BASE_W-1:0]  base;
    logic [SIZE_W-1:0]  size;
    logic [OWNER_W-1:0] owner;
    logic               last;
  } request_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [BASE_W-1:0]  placed;
    logic [OWNER_W-1:0] owner;
    logic               done;
    logic               committed;
  } reply_t;

  class placement_tracker;
    logic [BASE_W-1:0] hole_base [MAX_HOLES];
    logic [SIZE_W-1:0] hole_len [MAX_HOLES];
    logic [BASE_W-1:0] snap_base [MAX_HOLES];
    logic [SIZE_W-1:0] snap_len [MAX_HOLES];
    int holes;
    bit proc_open;
    bit proc_failed;
    reply_t replies_due[$];
    int errors;
    int n_added, n_full, n_placed, n_nofit, n_skipped, n_commit, n_rollback;

    function void note_request(request_t rq);
      reply_t r;
      int best;
      r.owner = rq.owner;
      r.placed = '0;
      r.done = 1'b0;
      r.committed = 1'b0;
      if (rq.action == ACT_ADD) begin
        if (holes < MAX_HOLES) begin
          hole_base[holes] = rq.base;
          hole_len[holes] = rq.size;
          if (proc_open) begin
            snap_base[holes] = rq.base;
            snap_len[holes] = rq.size;
          end
          holes++;
          r.status = ST_ADDED;
        end else begin
          r.status = ST_FULL;
        end
      end else begin
        if (!proc_open) begin
          snap_base = hole_base;
          snap_len = hole_len;
          proc_open = 1'b1;
          proc_failed = 1'b0;
        end
        if (proc_failed) begin
          r.status = ST_SKIPPED;
        end else begin
          best = -1;
          for (int i = 0; i < holes; i++) begin
            if (rq.size <= hole_len[i] && (best < 0 || hole_len[i] < hole_len[best]))
              best = i;
          end
          if (best >= 0) begin
            r.placed = hole_base[best];
            hole_base[best] = hole_base[best] + rq.size[BASE_W-1:0];
            hole_len[best] = hole_len[best] - rq.size;
            r.status = ST_PLACED;
          end else begin
            proc_failed = 1'b1;
            r.status = ST_NOFIT;
          end
        end
        if (rq.last) begin
          r.done = 1'b1;
          r.committed = !proc_failed;
          if (proc_failed) begin
            for (int i = 0; i < holes; i++) begin
              hole_base[i] = snap_base[i];
              hole_len[i] = snap_len[i];
            end
            n_rollback++;
          end else begin
            n_commit++;
          end
          proc_open = 1'b0;
          proc_failed = 1'b0;
        end
      end
      case (r.status)
        ST_ADDED: n_added++;
        ST_FULL: n_full++;
        ST_PLACED: n_placed++;
        ST_NOFIT: n_nofit++;
        default: n_skipped++;
      endcase
      replies_due.insert(replies_due.size(), r);
    endfunction

    function void compare(string field, int want, int seen);
      if (want != seen) begin
        $error("%s expected %0d got %0d", field, want, seen);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("word with no request pending: status %0d owner %0d", got.status, got.owner);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      compare("status", want.status, got.status);
      compare("placed_base", want.placed, got.placed);
      compare("owner_echo", want.owner, got.owner);
      compare("process_done", want.done, got.done);
      compare("process_committed", want.committed, got.committed);
    endfunction

    function int waiting();
      return replies_due.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                action = ACT_ADD;
  logic [BASE_W-1:0]   region_base = '0;
  logic [SIZE_W-1:0]   region_size = '0;
  logic [OWNER_W-1:0]  owner_id = '0;
  logic                last_segment = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STAT_W-1:0]   status;
  logic [BASE_W-1:0]   placed_base;
  logic [OWNER_W-1:0]  owner_echo;
  logic                process_done;
  logic                process_committed;

  placement_tracker tracker = new;
  int words_sent = 0;
  int replies_checked = 0;
  int send_calm = 0;
  int recv_calm = 0;
  int cycles = 0;

  best_fit_segment_allocator DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .action            (action),
    .region_base       (region_base),
    .region_size       (region_size),
    .owner_id          (owner_id),
    .last_segment      (last_segment),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .placed_base       (placed_base),
    .owner_echo        (owner_echo),
    .process_done      (process_done),
    .process_committed (process_committed)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[best_fit_segment_allocator] ERROR");
      $finish;
    end
  end

  // zero-gap stretches now and then, otherwise a random idle gap
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic logic [SIZE_W-1:0] pick_hole_len();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SIZE_W'($urandom_range(1, 64));
      2: return 17'd65536;
      default: return SIZE_W'($urandom_range(1024, 65535));
    endcase
  endfunction

  function automatic logic [SIZE_W-1:0] pick_seg_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 55) return SIZE_W'($urandom_range(1, 64));
    if (r < 80) return SIZE_W'($urandom_range(65, 2048));
    if (r < 95) return SIZE_W'($urandom_range(2049, 16384));
    if (r < 97) return 17'd65536;
    return SIZE_W'($urandom_range(30000, 65536));
  endfunction

  task automatic send_word(request_t rq);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    action = rq.action;
    region_base = rq.base;
    region_size = rq.size;
    owner_id = rq.owner;
    last_segment = rq.last;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(rq);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic add_hole(logic [BASE_W-1:0] base, logic [SIZE_W-1:0] len,
                          logic [OWNER_W-1:0] owner);
    send_word('{ACT_ADD, base, len, owner, 1'($urandom)});
  endtask

  task automatic alloc(logic [SIZE_W-1:0] len, logic [OWNER_W-1:0] owner, logic last);
    send_word('{ACT_ALLOC, 16'($urandom), len, owner, last});
  endtask

  initial begin
    int stall;
    bit held_off;
    held_off = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!held_off && replies_checked >= HOLD_AT) begin
        held_off = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = draw_gap(recv_calm);
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      tracker.check_reply('{status, placed_base, owner_echo, process_done, process_committed});
      replies_checked++;
      @(negedge clk);
    end
  end

  initial begin
    int nseg;
    int target;
    bit paused;
    logic [OWNER_W-1:0] owner;
    paused = 1'b0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // empty table, zero-size segment still finds nothing
    alloc(17'd0, 8'h00, 1'b1);
    add_hole(16'h0000, 17'd0, 8'h00);
    add_hole(16'hFFFF, 17'd65536, 8'hFF);
    add_hole(16'd100, 17'd500, 8'h01);
    add_hole(16'd2000, 17'd500, 8'h02);
    // zero size fits the zero-length hole, then ties go to the lower index
    alloc(17'd0, 8'h00, 1'b0);
    alloc(17'd200, 8'h00, 1'b0);
    add_hole(16'd40000, 17'd300, 8'h00);
    alloc(17'd300, 8'h00, 1'b1);
    // full-size carve wraps, then a failure, skips and a rollback
    alloc(17'd65536, 8'hFF, 1'b0);
    alloc(17'd65536, 8'hFF, 1'b0);
    alloc(17'd1, 8'hFF, 1'b0);
    add_hole(16'd1234, 17'd7000, 8'hFF);
    alloc(17'd1, 8'hFF, 1'b1);
    alloc(17'd65536, 8'h03, 1'b1);
    alloc(17'd65536, 8'h04, 1'b1);
    // partial carve past the top of memory
    add_hole(16'hFF00, 17'd1024, 8'h05);
    alloc(17'd512, 8'h09, 1'b1);
    alloc(17'd512, 8'h0A, 1'b1);
    alloc(17'd7000, 8'hAA, 1'b0);
    alloc(17'd131071 & 17'd65535, 8'h55, 1'b1);

    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      if (!paused && words_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid = 1'b0;
        while (tracker.waiting() != 0) @(negedge clk);
      end
      if ($urandom_range(0, 11) == 0) begin
        add_hole(16'($urandom), pick_hole_len(), 8'($urandom));
      end else begin
        nseg = $urandom_range(1, 5);
        owner = 8'($urandom);
        for (int k = 0; k < nseg; k++) begin
          if ($urandom_range(0, 9) == 0)
            add_hole(16'($urandom), pick_hole_len(), owner);
          if ($urandom_range(0, 19) == 0)
            owner = 8'($urandom);
          alloc(pick_seg_size(), owner, (k == nseg - 1) && ($urandom_range(0, 19) != 0));
        end
      end
    end
    in_valid = 1'b0;

    while (tracker.waiting() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d words: %0d holes added, %0d table full, %0d placed, %0d no fit, %0d skipped",
             words_sent, tracker.n_added, tracker.n_full, tracker.n_placed,
             tracker.n_nofit, tracker.n_skipped);
    $display("%0d processes committed, %0d rolled back", tracker.n_commit,
             tracker.n_rollback);
    if (tracker.errors == 0) begin
      $display("[best_fit_segment_allocator] OK");
    end else begin
      $display("[best_fit_segment_allocator] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: best_fit_segment_allocator.f
+incdir+rtl
rtl/bfsa_pkg.sv
rtl/bfsa_ctrl.sv
rtl/bfsa_dp.sv
rtl/best_fit_segment_allocator.sv
tb/tb_best_fit_segment_allocator.sv
